/* src/bstk_pkg.sv */
// shared types and constants for the bounded sorted top-k table
package bstk_pkg;

  // operation codes carried in the input tuser
  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_FIND   = 3'd1;
  localparam logic [2:0] KIND_ADD_IF = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 152;

  // one table record
  typedef struct packed {
    logic signed [31:0] score;
    logic [31:0]        name;
    logic [31:0]        stamp;
    logic [31:0]        random;
  } rec_t;

  // commands broadcast from the controller to every cell
  typedef struct packed {
    logic eval;   // register compare flags against the candidate
    logic upd;    // apply insert and shift
    logic clr;    // empty the table
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

endpackage

/* src/bstk_cell.sv */
// one slot of the sorted table: holds a record, compares it, shifts from its left neighbor
module bstk_cell (
  input  logic                clk,
  input  logic                rst,
  input  bstk_pkg::cell_ctl_t ctl,
  input  bstk_pkg::rec_t      cand,
  input  bstk_pkg::rec_t      left_rec,
  input  logic                left_valid,
  input  logic                left_ge,
  output bstk_pkg::rec_t      rec,
  output logic                valid,
  output logic                ge,
  output logic                match
);
  import bstk_pkg::*;

  logic take;

  // a slot that does not keep its entry either takes the candidate or its neighbor's entry
  assign take = ctl.upd && !ge;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= left_ge ? 1'b1 : left_valid;
    end
  end

  // record payload
  always_ff @(posedge clk) begin
    if (take) begin
      rec <= left_ge ? cand : left_rec;
    end
  end

  // compare flags: entry stays in place, entry equals candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      ge    <= 1'b0;
      match <= 1'b0;
    end else if (ctl.eval) begin
      ge    <= valid && !(rec.score < cand.score);
      match <= valid && (rec == cand);
    end
  end

endmodule

/* src/bounded_sorted_topk_table.sv */
// top level of the bounded sorted top-k table: cell chain, controller and result register
//
//   channel | dir | handshake        | payload
//   s_*     | in  | s_tvalid/tready  | s_tdata records and read index, s_tuser kind
//   m_*     | out | m_tvalid/tready  | m_tdata status and read-back entry
//
// each item passes through ST_IDLE, which registers every cell's compare flags,
// then ST_EVAL, which inserts/shifts the chain and loads the result register.
// a new item is taken while the previous result still waits on m_tready;
// ST_EVAL holds until the result register is free.
// rst is synchronous and empties the table; no clearing pass is needed.
module bounded_sorted_topk_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // score[31:0], name_tag[63:32], stamp[95:64], random_tag[127:96],
  // read_index[131:128], zero[135:132]
  input  logic [bstk_pkg::IN_DATA_W-1:0]      s_tdata,
  // kind[2:0]
  input  logic [2:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // accepted[0], position[5:1], match_index[10:6], entry_count[15:11],
  // read_valid[16], read_score[48:17], read_name[80:49], read_stamp[112:81],
  // read_random[144:113], zero[151:145]
  output logic [bstk_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import bstk_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_t         state, state_next;
  rec_t           item_rec;
  logic [2:0]     item_kind;
  logic [3:0]     item_idx;
  rec_t           s_rec;
  rec_t           cand;
  cell_ctl_t      ctl;
  logic [CW-1:0]  count, count_next;
  logic           out_free;
  logic           finish;
  logic [OUT_DATA_W-1:0] result;

  rec_t           rec_a   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_v;
  logic [MAX_ENTRIES-1:0] ge_v;
  logic [MAX_ENTRIES-1:0] match_v;

  // input unpacking
  assign s_rec.score  = s_tdata[31:0];
  assign s_rec.name   = s_tdata[63:32];
  assign s_rec.stamp  = s_tdata[95:64];
  assign s_rec.random = s_tdata[127:96];

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == ST_EVAL) && out_free;
  assign cand     = (state == ST_IDLE) ? s_rec : item_rec;

  // held item
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_rec  <= s_rec;
      item_kind <= s_tuser;
      item_idx  <= s_tdata[131:128];
    end
  end

  // cell chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    rec_t lrec;
    logic lvalid;
    logic lge;
    if (i == 0) begin : g_head
      assign lrec   = '0;
      assign lvalid = 1'b0;
      assign lge    = 1'b1;
    end else begin : g_link
      assign lrec   = rec_a[i-1];
      assign lvalid = valid_v[i-1];
      assign lge    = ge_v[i-1];
    end
    bstk_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cand       (cand),
      .left_rec   (lrec),
      .left_valid (lvalid),
      .left_ge    (lge),
      .rec        (rec_a[i]),
      .valid      (valid_v[i]),
      .ge         (ge_v[i]),
      .match      (match_v[i])
    );
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // controller: next state, cell commands, result word
  always_comb begin
    logic          found;
    logic [CW-1:0] pos;
    logic          any_match;
    logic [CW-1:0] mfirst;
    logic          add_go;
    logic          stored;
    logic          rd_ok;
    rec_t          rd_rec;
    logic [4:0]    res_pos;
    logic [4:0]    res_match;
    found     = 1'b0;
    pos       = CW'(MAX_ENTRIES);
    any_match = 1'b0;
    mfirst    = '0;
    rd_rec    = '0;
    // first slot that gives way, first exact match
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!ge_v[i]) begin
        found = 1'b1;
        pos   = CW'(i);
      end
      if (match_v[i]) begin
        any_match = 1'b1;
        mfirst    = CW'(i + 1);
      end
    end
    // read-back select
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (32'(item_idx) == i) begin
        rd_rec = rec_a[i];
      end
    end
    rd_ok  = (32'(item_idx) < 32'(count));
    add_go = (item_kind == KIND_ADD) || ((item_kind == KIND_ADD_IF) && !any_match);
    stored = add_go && found;

    state_next = state;
    ctl        = '0;
    count_next = count;
    res_pos    = '0;
    res_match  = '0;
    result     = '0;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ctl.eval   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          state_next = ST_IDLE;
          if (item_kind == KIND_CLEAR) begin
            ctl.clr    = 1'b1;
            count_next = '0;
          end
          if (stored) begin
            ctl.upd = 1'b1;
            if (count != CW'(MAX_ENTRIES)) begin
              count_next = count + 1'b1;
            end
          end
          if (add_go) begin
            res_pos = stored ? 5'(pos) : 5'(MAX_ENTRIES);
          end else if (item_kind == KIND_ADD_IF) begin
            res_pos = 5'(MAX_ENTRIES);
          end
          if ((item_kind == KIND_FIND) || (item_kind == KIND_ADD_IF)) begin
            res_match = 5'(mfirst);
          end
          result[0]     = stored;
          result[5:1]   = res_pos;
          result[10:6]  = res_match;
          result[15:11] = 5'(count_next);
          if ((item_kind == KIND_READ) && rd_ok) begin
            result[16]      = 1'b1;
            result[48:17]   = rd_rec.score;
            result[80:49]   = rd_rec.name;
            result[112:81]  = rd_rec.stamp;
            result[144:113] = rd_rec.random;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= result;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) 32'(count) <= MAX_ENTRIES)
    else $error("entry count above table size");

  assert property (@(posedge clk) disable iff (rst) $countones(valid_v) == 32'(count))
    else $error("occupied cells disagree with entry count");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_EVAL))
    else $error("result appeared without an evaluated item");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) && !out_free |=> (state == ST_EVAL) && $stable(count))
    else $error("table changed while the result register was busy");

endmodule
